/* src/bfsra_pkg.sv */
// Shared types and constants of the best-fit slot range allocator.
`timescale 1ns / 1ps

package bfsra_pkg;

    // Largest pool the free list can describe
    localparam logic [16:0] SLOT_LIMIT = 17'h10000;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [1:0] CFG_PRODUCERS = 2'd1;

    // Request codes
    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_PRODUCER  = 3'd1,
        ST_ZERO_COUNT   = 3'd2,
        ST_NO_FIT       = 3'd3,
        ST_NOT_RESERVED = 3'd4,
        ST_MISMATCH     = 3'd5,
        ST_TABLE_FULL   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FSCAN,
        S_COMMIT,
        S_RSCAN,
        S_PSCAN,
        S_FINS,
        S_FPUT,
        S_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] len;
    } free_run_t;

    typedef struct packed {
        logic [3:0]  owner;
        logic [15:0] start;
        logic [16:0] len;
    } resv_t;

endpackage

/* src/bfsra_list.sv */
// Ordered list store: memory with one read and one write port and a built-in entry shift engine.
`timescale 1ns / 1ps

module bfsra_list #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     shift_start,
    input  logic                     shift_up,
    input  logic [$clog2(DEPTH)-1:0] shift_lo,
    input  logic [$clog2(DEPTH)-1:0] shift_hi,
    output logic                     shift_busy
);

    localparam int IW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    logic          busy_reg,  busy_next;
    logic          issue_reg, issue_next;
    logic          pend_reg,  pend_next;
    logic          up_reg,    up_next;
    logic [IW-1:0] src_reg,   src_next;
    logic [IW-1:0] end_reg,   end_next;
    logic [IW-1:0] dst_reg,   dst_next;

    logic [IW-1:0]    mem_raddr;
    logic [IW-1:0]    mem_waddr;
    logic             mem_we;
    logic [WIDTH-1:0] mem_wdata;

    // Shift engine owns the memory while busy
    always_comb begin
        mem_raddr = busy_reg ? src_reg : rd_addr;
        mem_we    = busy_reg ? pend_reg : wr_en;
        mem_waddr = busy_reg ? dst_reg : wr_addr;
        mem_wdata = busy_reg ? rdata_reg : wr_data;
    end

    // Step one entry per cycle: read the source, write it one place over
    always_comb begin
        busy_next  = busy_reg;
        issue_next = issue_reg;
        pend_next  = 1'b0;
        up_next    = up_reg;
        src_next   = src_reg;
        end_next   = end_reg;
        dst_next   = dst_reg;
        if (busy_reg) begin
            busy_next = issue_reg;
            if (issue_reg) begin
                pend_next = 1'b1;
                dst_next  = up_reg ? IW'(src_reg + 1'b1) : IW'(src_reg - 1'b1);
                if (src_reg == end_reg) begin
                    issue_next = 1'b0;
                end else begin
                    src_next = up_reg ? IW'(src_reg - 1'b1) : IW'(src_reg + 1'b1);
                end
            end
        end else if (shift_start && (shift_lo < shift_hi)) begin
            busy_next  = 1'b1;
            issue_next = 1'b1;
            up_next    = shift_up;
            src_next   = shift_up ? IW'(shift_hi - 1'b1) : IW'(shift_lo + 1'b1);
            end_next   = shift_up ? shift_lo : shift_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        up_reg  <= up_next;
        src_reg <= src_next;
        end_reg <= end_next;
        dst_reg <= dst_next;
    end

    // Memory array with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign rd_data    = rdata_reg;
    assign shift_busy = busy_reg;

endmodule

/* src/best_fit_slot_range_allocator.sv */
// Top level of the best-fit slot range allocator with coalescing free list.
`timescale 1ns / 1ps

// Channel   Ports                                           Handshake
// input     s_cmd s_producer s_range_first s_range_count    s_valid / s_ready
// result    m_status m_first_slot m_high_mark              m_valid / m_ready
// config    cfg_index cfg_wdata                             cfg_we (no wait)
//
// One item at a time. A reserve scans the free list (one run per cycle), then
// erases or trims the chosen run; a release scans the reservation table, then
// the free list, then shifts entries. Shifts move one entry per cycle.
// Reset or a capacity write rebuilds the free list in the S_INIT state.
// A result held by m_ready low does not block the next item from being taken,
// but that item's result waits in S_DONE until the held result is taken.

module best_fit_slot_range_allocator #(
    parameter int MAX_RESERVATIONS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_producer,
    input  logic [15:0] s_range_first,
    input  logic [16:0] s_range_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_first_slot,
    output logic [16:0] m_high_mark,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);

    localparam int FREE_DEPTH = MAX_RESERVATIONS + 1;
    localparam int FIW = $clog2(FREE_DEPTH);
    localparam int FCW = $clog2(FREE_DEPTH + 1);
    localparam int RIW = $clog2(MAX_RESERVATIONS);
    localparam int RCW = $clog2(MAX_RESERVATIONS + 1);
    localparam int FW  = $bits(bfsra_pkg::free_run_t);
    localparam int RW  = $bits(bfsra_pkg::resv_t);

    bfsra_pkg::state_t state_reg, state_next;

    logic [16:0]        capacity_reg,   capacity_next;
    logic [4:0]         producers_reg,  producers_next;
    logic [FCW-1:0]     free_total_reg, free_total_next;
    logic [RCW-1:0]     resv_total_reg, resv_total_next;
    logic [16:0]        high_mark_reg,  high_mark_next;
    logic               m_valid_reg,    m_valid_next;

    logic [FCW-1:0]     scan_idx_reg,   scan_idx_next;
    logic               scan_pv_reg,    scan_pv_next;
    logic [FCW-1:0]     scan_pidx_reg,  scan_pidx_next;

    logic [3:0]         producer_reg,   producer_next;
    logic [15:0]        first_reg,      first_next;
    logic [16:0]        count_reg,      count_next;
    bfsra_pkg::status_t status_reg,     status_next;
    logic [15:0]        granted_reg,    granted_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [FIW-1:0]     hold_idx_reg,   hold_idx_next;
    logic [15:0]        hold_start_reg, hold_start_next;
    logic [16:0]        hold_len_reg,   hold_len_next;
    logic               nxt_valid_reg,  nxt_valid_next;
    logic [15:0]        nxt_start_reg,  nxt_start_next;
    logic [16:0]        nxt_len_reg,    nxt_len_next;
    logic [FCW-1:0]     pos_reg,        pos_next;
    logic [2:0]         m_status_reg,   m_status_next;
    logic [15:0]        m_first_reg,    m_first_next;
    logic [16:0]        m_high_reg,     m_high_next;

    // Free list port
    logic [FIW-1:0] f_rd_addr, f_wr_addr, f_shift_lo, f_shift_hi;
    logic [FW-1:0]  f_rd_data, f_wr_data;
    logic           f_wr_en, f_shift_start, f_shift_up, f_busy;
    // Reservation table port
    logic [RIW-1:0] r_rd_addr, r_wr_addr, r_shift_lo, r_shift_hi;
    logic [RW-1:0]  r_rd_data, r_wr_data;
    logic           r_wr_en, r_shift_start, r_busy;

    bfsra_pkg::free_run_t f_rd;
    bfsra_pkg::resv_t     r_rd;

    logic [FCW-1:0] scan_len;
    logic           scan_more;
    logic           scan_end;
    logic [16:0]    slots;
    logic [17:0]    rel_end;
    logic [17:0]    prev_end;
    logic [16:0]    grant_end;
    logic           merge_next;
    logic           merge_prev;

    bfsra_list #(.WIDTH(FW), .DEPTH(FREE_DEPTH)) u_free (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_addr     (f_rd_addr),
        .rd_data     (f_rd_data),
        .wr_en       (f_wr_en),
        .wr_addr     (f_wr_addr),
        .wr_data     (f_wr_data),
        .shift_start (f_shift_start),
        .shift_up    (f_shift_up),
        .shift_lo    (f_shift_lo),
        .shift_hi    (f_shift_hi),
        .shift_busy  (f_busy)
    );

    bfsra_list #(.WIDTH(RW), .DEPTH(MAX_RESERVATIONS)) u_resv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_addr     (r_rd_addr),
        .rd_data     (r_rd_data),
        .wr_en       (r_wr_en),
        .wr_addr     (r_wr_addr),
        .wr_data     (r_wr_data),
        .shift_start (r_shift_start),
        .shift_up    (1'b0),
        .shift_lo    (r_shift_lo),
        .shift_hi    (r_shift_hi),
        .shift_busy  (r_busy)
    );

    // Derived values used across states
    always_comb begin
        f_rd      = bfsra_pkg::free_run_t'(f_rd_data);
        r_rd      = bfsra_pkg::resv_t'(r_rd_data);
        slots     = (capacity_reg > bfsra_pkg::SLOT_LIMIT) ? bfsra_pkg::SLOT_LIMIT
                                                           : capacity_reg;
        scan_len  = (state_reg == bfsra_pkg::S_RSCAN) ? FCW'(resv_total_reg)
                                                      : free_total_reg;
        scan_more = scan_idx_reg < scan_len;
        scan_end  = !scan_pv_reg && !scan_more;
        rel_end   = {2'b00, first_reg} + {1'b0, count_reg};
        prev_end  = {2'b00, hold_start_reg} + {1'b0, hold_len_reg};
        grant_end = {1'b0, hold_start_reg} + count_reg;
        merge_next = nxt_valid_reg && (rel_end == {2'b00, nxt_start_reg});
        merge_prev = hold_valid_reg && (prev_end == {2'b00, first_reg});
    end

    assign s_ready = (state_reg == bfsra_pkg::S_IDLE) && !cfg_we;

    // Sequencer: next state, datapath and list commands
    always_comb begin
        state_next      = state_reg;
        capacity_next   = capacity_reg;
        producers_next  = producers_reg;
        free_total_next = free_total_reg;
        resv_total_next = resv_total_reg;
        high_mark_next  = high_mark_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        scan_idx_next   = scan_idx_reg;
        scan_pv_next    = 1'b0;
        scan_pidx_next  = scan_pidx_reg;
        producer_next   = producer_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        hold_start_next = hold_start_reg;
        hold_len_next   = hold_len_reg;
        nxt_valid_next  = nxt_valid_reg;
        nxt_start_next  = nxt_start_reg;
        nxt_len_next    = nxt_len_reg;
        pos_next        = pos_reg;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        m_high_next     = m_high_reg;

        f_rd_addr     = scan_idx_reg[FIW-1:0];
        f_wr_en       = 1'b0;
        f_wr_addr     = '0;
        f_wr_data     = '0;
        f_shift_start = 1'b0;
        f_shift_up    = 1'b0;
        f_shift_lo    = '0;
        f_shift_hi    = '0;
        r_rd_addr     = scan_idx_reg[RIW-1:0];
        r_wr_en       = 1'b0;
        r_wr_addr     = resv_total_reg[RIW-1:0];
        r_wr_data     = {producer_reg, hold_start_reg, count_reg};
        r_shift_start = 1'b0;
        r_shift_lo    = '0;
        r_shift_hi    = '0;

        // Issue one list read per cycle while scanning
        if ((state_reg == bfsra_pkg::S_FSCAN || state_reg == bfsra_pkg::S_RSCAN ||
             state_reg == bfsra_pkg::S_PSCAN) && scan_more) begin
            scan_pv_next   = 1'b1;
            scan_pidx_next = scan_idx_reg;
            scan_idx_next  = FCW'(scan_idx_reg + 1'b1);
        end

        unique case (state_reg)
            bfsra_pkg::S_INIT: begin
                f_wr_en         = slots != '0;
                f_wr_data       = {16'd0, slots};
                free_total_next = (slots != '0) ? FCW'(1) : '0;
                resv_total_next = '0;
                high_mark_next  = '0;
                state_next      = bfsra_pkg::S_IDLE;
            end
            bfsra_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    producer_next   = s_producer;
                    first_next      = s_range_first;
                    count_next      = s_range_count;
                    granted_next    = '0;
                    status_next     = bfsra_pkg::ST_OK;
                    scan_idx_next   = '0;
                    hold_valid_next = 1'b0;
                    nxt_valid_next  = 1'b0;
                    if ({1'b0, s_producer} >= producers_reg) begin
                        status_next = bfsra_pkg::ST_NO_PRODUCER;
                        state_next  = bfsra_pkg::S_DONE;
                    end else if (s_cmd == bfsra_pkg::CMD_RELEASE) begin
                        state_next = bfsra_pkg::S_RSCAN;
                    end else if (s_range_count == '0) begin
                        status_next = bfsra_pkg::ST_ZERO_COUNT;
                        state_next  = bfsra_pkg::S_DONE;
                    end else begin
                        state_next = bfsra_pkg::S_FSCAN;
                    end
                end
            end
            bfsra_pkg::S_FSCAN: begin
                // Keep the smallest fitting run, lowest on a tie
                if (scan_pv_reg && f_rd.len >= count_reg &&
                    (!hold_valid_reg || f_rd.len < hold_len_reg)) begin
                    hold_valid_next = 1'b1;
                    hold_idx_next   = scan_pidx_reg[FIW-1:0];
                    hold_start_next = f_rd.start;
                    hold_len_next   = f_rd.len;
                end
                if (scan_end) begin
                    if (!hold_valid_reg) begin
                        status_next = bfsra_pkg::ST_NO_FIT;
                        state_next  = bfsra_pkg::S_DONE;
                    end else if (resv_total_reg >= RCW'(MAX_RESERVATIONS)) begin
                        status_next = bfsra_pkg::ST_TABLE_FULL;
                        state_next  = bfsra_pkg::S_DONE;
                    end else begin
                        state_next = bfsra_pkg::S_COMMIT;
                    end
                end
            end
            bfsra_pkg::S_COMMIT: begin
                // Record the reservation, then trim or drop the run
                granted_next    = hold_start_reg;
                r_wr_en         = 1'b1;
                resv_total_next = RCW'(resv_total_reg + 1'b1);
                if (grant_end > high_mark_reg) begin
                    high_mark_next = grant_end;
                end
                if (hold_len_reg == count_reg) begin
                    f_shift_start   = 1'b1;
                    f_shift_lo      = hold_idx_reg;
                    f_shift_hi      = FIW'(free_total_reg - 1'b1);
                    free_total_next = FCW'(free_total_reg - 1'b1);
                end else begin
                    f_wr_en   = 1'b1;
                    f_wr_addr = hold_idx_reg;
                    f_wr_data = {grant_end[15:0], 17'(hold_len_reg - count_reg)};
                end
                state_next = bfsra_pkg::S_WAIT;
            end
            bfsra_pkg::S_RSCAN: begin
                if (scan_pv_reg && r_rd.start == first_reg) begin
                    if (r_rd.owner != producer_reg || r_rd.len != count_reg) begin
                        status_next = bfsra_pkg::ST_MISMATCH;
                        state_next  = bfsra_pkg::S_DONE;
                    end else begin
                        // Drop the reservation while the free list is searched
                        r_shift_start   = 1'b1;
                        r_shift_lo      = scan_pidx_reg[RIW-1:0];
                        r_shift_hi      = RIW'(resv_total_reg - 1'b1);
                        resv_total_next = RCW'(resv_total_reg - 1'b1);
                        scan_idx_next   = '0;
                        scan_pv_next    = 1'b0;
                        state_next      = bfsra_pkg::S_PSCAN;
                    end
                end else if (scan_end) begin
                    status_next = bfsra_pkg::ST_NOT_RESERVED;
                    state_next  = bfsra_pkg::S_DONE;
                end
            end
            bfsra_pkg::S_PSCAN: begin
                // Find the first run at or after the released start
                if (scan_pv_reg) begin
                    if (f_rd.start >= first_reg) begin
                        pos_next       = scan_pidx_reg;
                        nxt_valid_next = 1'b1;
                        nxt_start_next = f_rd.start;
                        nxt_len_next   = f_rd.len;
                        state_next     = bfsra_pkg::S_FINS;
                    end else begin
                        hold_valid_next = 1'b1;
                        hold_start_next = f_rd.start;
                        hold_len_next   = f_rd.len;
                    end
                end else if (scan_end) begin
                    pos_next   = free_total_reg;
                    state_next = bfsra_pkg::S_FINS;
                end
            end
            bfsra_pkg::S_FINS: begin
                state_next = bfsra_pkg::S_WAIT;
                if (free_total_reg < FCW'(FREE_DEPTH)) begin
                    if (merge_prev) begin
                        f_wr_en   = 1'b1;
                        f_wr_addr = FIW'(pos_reg - 1'b1);
                        f_wr_data = merge_next ?
                            {hold_start_reg, 17'(hold_len_reg + count_reg + nxt_len_reg)} :
                            {hold_start_reg, 17'(hold_len_reg + count_reg)};
                        if (merge_next) begin
                            f_shift_start   = 1'b1;
                            f_shift_lo      = pos_reg[FIW-1:0];
                            f_shift_hi      = FIW'(free_total_reg - 1'b1);
                            free_total_next = FCW'(free_total_reg - 1'b1);
                        end
                    end else if (merge_next) begin
                        f_wr_en   = 1'b1;
                        f_wr_addr = pos_reg[FIW-1:0];
                        f_wr_data = {first_reg, 17'(count_reg + nxt_len_reg)};
                    end else begin
                        // Open a gap, then place the run
                        f_shift_start = 1'b1;
                        f_shift_up    = 1'b1;
                        f_shift_lo    = pos_reg[FIW-1:0];
                        f_shift_hi    = free_total_reg[FIW-1:0];
                        state_next    = bfsra_pkg::S_FPUT;
                    end
                end
            end
            bfsra_pkg::S_FPUT: begin
                if (!f_busy) begin
                    f_wr_en         = 1'b1;
                    f_wr_addr       = pos_reg[FIW-1:0];
                    f_wr_data       = {first_reg, count_reg};
                    free_total_next = FCW'(free_total_reg + 1'b1);
                    state_next      = bfsra_pkg::S_WAIT;
                end
            end
            bfsra_pkg::S_WAIT: begin
                if (!f_busy && !r_busy) begin
                    state_next = bfsra_pkg::S_DONE;
                end
            end
            bfsra_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_first_next  = granted_reg;
                    m_high_next   = high_mark_next;
                    state_next    = bfsra_pkg::S_IDLE;
                end
            end
            default: state_next = bfsra_pkg::S_INIT;
        endcase

        // Configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                bfsra_pkg::CFG_CAPACITY: begin
                    capacity_next = cfg_wdata;
                    state_next    = bfsra_pkg::S_INIT;
                end
                bfsra_pkg::CFG_PRODUCERS: producers_next = cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfsra_pkg::S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= 17'h10000;
            producers_reg  <= '0;
            free_total_reg <= '0;
            resv_total_reg <= '0;
            high_mark_reg  <= '0;
            m_valid_reg    <= 1'b0;
            scan_pv_reg    <= 1'b0;
        end else begin
            capacity_reg   <= capacity_next;
            producers_reg  <= producers_next;
            free_total_reg <= free_total_next;
            resv_total_reg <= resv_total_next;
            high_mark_reg  <= high_mark_next;
            m_valid_reg    <= m_valid_next;
            scan_pv_reg    <= scan_pv_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        scan_pidx_reg  <= scan_pidx_next;
        producer_reg   <= producer_next;
        first_reg      <= first_next;
        count_reg      <= count_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        hold_valid_reg <= hold_valid_next;
        hold_idx_reg   <= hold_idx_next;
        hold_start_reg <= hold_start_next;
        hold_len_reg   <= hold_len_next;
        nxt_valid_reg  <= nxt_valid_next;
        nxt_start_reg  <= nxt_start_next;
        nxt_len_reg    <= nxt_len_next;
        pos_reg        <= pos_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
        m_high_reg     <= m_high_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_first_slot = m_first_reg;
    assign m_high_mark  = m_high_reg;

    a_resv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        resv_total_reg <= RCW'(MAX_RESERVATIONS))
        else $error("reservation count above table depth");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= FCW'(FREE_DEPTH))
        else $error("free run count above list depth");

    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!f_busy && !r_busy))
        else $error("item taken while a list shift is running");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bfsra_pkg::S_DONE))
        else $error("result raised outside the completion step");

endmodule

/* tb/sv/best_fit_slot_range_allocator_checker.sv */
// Checker for the best-fit slot range allocator: predicts every result and compares it.
`timescale 1ns / 1ps

module best_fit_slot_range_allocator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_producer,
    input  logic [15:0] s_range_first,
    input  logic [16:0] s_range_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [15:0] m_first_slot,
    input  logic [16:0] m_high_mark,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    localparam int RESV_DEPTH = 64;
    localparam int RUN_DEPTH  = RESV_DEPTH + 1;

    typedef struct packed {
        bfsra_pkg::status_t status;
        logic [15:0]        first_slot;
        logic [16:0]        peak;
    } grant_t;

    // Model copy of the allocator state
    logic [16:0] pool_slots;
    logic [4:0]  producers_live;
    int          run_start [RUN_DEPTH];
    int          run_len   [RUN_DEPTH];
    int          run_total;
    int          book_start [RESV_DEPTH];
    int          book_len   [RESV_DEPTH];
    int          book_owner [RESV_DEPTH];
    int          book_total;
    int          peak_end;
    grant_t      grant_queue[$];

    function automatic void rebuild_pool();
        int slots;
        slots = pool_slots;
        if (slots > 65536) slots = 65536;
        run_total = 0;
        if (slots != 0) begin
            run_start[0] = 0;
            run_len[0] = slots;
            run_total = 1;
        end
        book_total = 0;
        peak_end = 0;
    endfunction

    function automatic void drop_run(int pos);
        for (int i = pos; i + 1 < run_total; i++) begin
            run_start[i] = run_start[i+1];
            run_len[i] = run_len[i+1];
        end
        run_total--;
    endfunction

    // Put a run back in address order and merge with neighbors
    function automatic void return_run(int first, int count);
        int pos;
        pos = 0;
        if (run_total >= RUN_DEPTH) return;
        while (pos < run_total && run_start[pos] < first) pos++;
        for (int i = run_total; i > pos; i--) begin
            run_start[i] = run_start[i-1];
            run_len[i] = run_len[i-1];
        end
        run_start[pos] = first;
        run_len[pos] = count;
        run_total++;
        if (pos + 1 < run_total && run_start[pos] + run_len[pos] == run_start[pos+1]) begin
            run_len[pos] += run_len[pos+1];
            drop_run(pos + 1);
        end
        if (pos > 0 && run_start[pos-1] + run_len[pos-1] == run_start[pos]) begin
            run_len[pos-1] += run_len[pos];
            drop_run(pos);
        end
    endfunction

    function automatic grant_t allocate(logic cmd, logic [3:0] who, logic [15:0] first,
                                        logic [16:0] count);
        grant_t g;
        int best, idx, cnt, fst;
        g.status = bfsra_pkg::ST_OK;
        g.first_slot = '0;
        cnt = count;
        fst = first;
        if ({1'b0, who} >= producers_live) begin
            g.status = bfsra_pkg::ST_NO_PRODUCER;
        end else if (cmd == bfsra_pkg::CMD_RESERVE) begin
            best = run_total;
            if (cnt == 0) begin
                g.status = bfsra_pkg::ST_ZERO_COUNT;
            end else begin
                for (int i = 0; i < run_total; i++) begin
                    if (run_len[i] >= cnt && (best == run_total || run_len[i] < run_len[best]))
                        best = i;
                end
                if (best == run_total) begin
                    g.status = bfsra_pkg::ST_NO_FIT;
                end else if (book_total >= RESV_DEPTH) begin
                    g.status = bfsra_pkg::ST_TABLE_FULL;
                end else begin
                    g.first_slot = run_start[best][15:0];
                    book_start[book_total] = run_start[best];
                    book_len[book_total] = cnt;
                    book_owner[book_total] = who;
                    book_total++;
                    if (run_start[best] + cnt > peak_end) peak_end = run_start[best] + cnt;
                    if (run_len[best] == cnt) begin
                        drop_run(best);
                    end else begin
                        run_start[best] += cnt;
                        run_len[best] -= cnt;
                    end
                end
            end
        end else begin
            idx = book_total;
            for (int i = 0; i < book_total; i++) begin
                if (book_start[i] == fst) begin
                    idx = i;
                    break;
                end
            end
            if (idx == book_total) begin
                g.status = bfsra_pkg::ST_NOT_RESERVED;
            end else if (book_owner[idx] != who || book_len[idx] != cnt) begin
                g.status = bfsra_pkg::ST_MISMATCH;
            end else begin
                for (int i = idx; i + 1 < book_total; i++) begin
                    book_start[i] = book_start[i+1];
                    book_len[i] = book_len[i+1];
                    book_owner[i] = book_owner[i+1];
                end
                book_total--;
                return_run(fst, cnt);
            end
        end
        g.peak = peak_end[16:0];
        return g;
    endfunction

    // Track config, predict accepted items, compare accepted results
    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            pool_slots = 17'h10000;
            producers_live = '0;
            rebuild_pool();
            grant_queue.delete();
            fail_count = 0;
        end else begin
            if (cfg_we && cfg_index == bfsra_pkg::CFG_CAPACITY) begin
                pool_slots = cfg_wdata;
                rebuild_pool();
            end else if (cfg_we && cfg_index == bfsra_pkg::CFG_PRODUCERS) begin
                producers_live = cfg_wdata[4:0];
            end
            if (s_valid && s_ready)
                grant_queue = {grant_queue,
                               allocate(s_cmd, s_producer, s_range_first, s_range_count)};
            if (m_valid && m_ready) begin
                if (grant_queue.size() == 0) begin
                    $display("%0t: unexpected result status=%0d first=%0d high=%0d",
                             $time, m_status, m_first_slot, m_high_mark);
                    fail_count++;
                end else begin
                    want = grant_queue.pop_front();
                    if (m_status !== want.status || m_first_slot !== want.first_slot ||
                        m_high_mark !== want.peak) begin
                        $display("%0t: mismatch expected status=%0d first=%0d high=%0d,",
                                 $time, want.status, want.first_slot, want.peak,
                                 " actual status=%0d first=%0d high=%0d",
                                 m_status, m_first_slot, m_high_mark);
                        fail_count++;
                    end
                end
            end
        end
        pending = grant_queue.size();
    end

endmodule

/* tb/sv/best_fit_slot_range_allocator_tb.sv */
// Testbench top of the best-fit slot range allocator: stimulus and verdict.
`timescale 1ns / 1ps

module best_fit_slot_range_allocator_tb;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = bfsra_pkg::CMD_RESERVE;
    logic [3:0]  s_producer = '0;
    logic [15:0] s_range_first = '0;
    logic [16:0] s_range_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_first_slot;
    logic [16:0] m_high_mark;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = bfsra_pkg::CFG_CAPACITY;
    logic [16:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          quiet_cycles = 0;
    logic [15:0] granted_starts[$];
    logic [16:0] granted_lens[$];
    logic [3:0]  granted_owners[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    best_fit_slot_range_allocator dut (.*);

    best_fit_slot_range_allocator_checker checker_inst (.*);

    // Receiver stall pattern
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on accepted handshakes
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hold valid and payload until the item is taken
    task automatic send_item(logic cmd, logic [3:0] who, logic [15:0] first,
                             logic [16:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_producer <= who;
        s_range_first <= first;
        s_range_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Write a register once every outstanding result has come back
    task automatic write_reg(logic [1:0] idx, logic [16:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int items, int slots);
        int k, pick;
        logic [15:0] st;
        for (int n = 0; n < items; n++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                send_item(bfsra_pkg::CMD_RESERVE, 4'($urandom_range(7)), 16'($urandom),
                          (k < 5) ? 17'($urandom) : 17'($urandom_range(1, slots / 8 + 1)));
            end else if (k < 85 && granted_starts.size() > 0) begin
                pick = $urandom_range(granted_starts.size() - 1);
                send_item(bfsra_pkg::CMD_RELEASE, granted_owners[pick], granted_starts[pick],
                          granted_lens[pick]);
                granted_starts.delete(pick);
                granted_lens.delete(pick);
                granted_owners.delete(pick);
            end else begin
                st = 16'($urandom);
                send_item(1'($urandom_range(1)), 4'($urandom), st, 17'($urandom));
            end
        end
    endtask

    // Collect grants from results: reserves with status ok carry their start
    logic        last_cmd_q[$];
    logic [16:0] last_cnt_q[$];
    logic [3:0]  last_who_q[$];
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            last_cmd_q = {last_cmd_q, s_cmd};
            last_cnt_q = {last_cnt_q, s_range_count};
            last_who_q = {last_who_q, s_producer};
        end
        if (aresetn && m_valid && m_ready && last_cmd_q.size() > 0) begin
            if (last_cmd_q[0] == bfsra_pkg::CMD_RESERVE && m_status == bfsra_pkg::ST_OK) begin
                granted_starts = {granted_starts, m_first_slot};
                granted_lens = {granted_lens, last_cnt_q[0]};
                granted_owners = {granted_owners, last_who_q[0]};
            end
            void'(last_cmd_q.pop_front());
            void'(last_cnt_q.pop_front());
            void'(last_who_q.pop_front());
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drain();

        // Directed: producers absent, then extremes and every status
        send_item(bfsra_pkg::CMD_RESERVE, 4'd0, 16'd0, 17'd1);
        drain();
        write_reg(bfsra_pkg::CFG_PRODUCERS, 17'd16);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd15, 16'hFFFF, 17'd0);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd3, 16'd0, 17'h1FFFF);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd3, 16'd0, 17'h10000);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd1, 16'd0, 17'd1);
        send_item(bfsra_pkg::CMD_RELEASE, 4'd1, 16'hFFFF, 17'd5);
        send_item(bfsra_pkg::CMD_RELEASE, 4'd1, 16'd0, 17'd0);
        drain();
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'd0);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd2, 16'd0, 17'd1);
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'h1FFFF);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd2, 16'd0, 17'h10000);
        send_item(bfsra_pkg::CMD_RELEASE, 4'd3, 16'd0, 17'h10000);
        send_item(bfsra_pkg::CMD_RELEASE, 4'd2, 16'd0, 17'h10000);
        drain();
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'd1);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd0, 16'd0, 17'd1);
        send_item(bfsra_pkg::CMD_RESERVE, 4'd0, 16'd0, 17'd1);
        drain();
        // Fill the table: 65 reserves of one slot
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'd200);
        granted_starts.delete(); granted_lens.delete(); granted_owners.delete();
        for (int i = 0; i < 65; i++) send_item(bfsra_pkg::CMD_RESERVE, i[3:0], 16'd0, 17'd1);
        write_reg(bfsra_pkg::CFG_PRODUCERS, 17'd0);
        send_item(bfsra_pkg::CMD_RELEASE, 4'd0, 16'd0, 17'd1);
        drain();

        // Random phases over several settings and idling mixes
        write_reg(bfsra_pkg::CFG_PRODUCERS, 17'd6);
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'd64);
        granted_starts.delete(); granted_lens.delete(); granted_owners.delete();
        random_phase(95, 64);
        drain();
        send_idle_pct = 73;
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'd1000);
        granted_starts.delete(); granted_lens.delete(); granted_owners.delete();
        random_phase(95, 1000);
        drain();
        send_idle_pct = 0;
        sink_stall_pct = 73;
        write_reg(bfsra_pkg::CFG_PRODUCERS, 17'd8);
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'h10000);
        granted_starts.delete(); granted_lens.delete(); granted_owners.delete();
        random_phase(95, 65536);
        drain();
        send_idle_pct = 20;
        sink_stall_pct = 20;
        write_reg(bfsra_pkg::CFG_CAPACITY, 17'd300);
        granted_starts.delete(); granted_lens.delete(); granted_owners.delete();
        random_phase(95, 300);
        drain();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/bfsra_pkg.sv
src/bfsra_list.sv
src/best_fit_slot_range_allocator.sv
tb/sv/best_fit_slot_range_allocator_checker.sv
tb/sv/best_fit_slot_range_allocator_tb.sv
